[rtl/bpru_pkg.sv]
// Shared types and constants for the bitmap pixel row unpacker.
package bpru_pkg;

	localparam int DEFAULT_MAX_WIDTH  = 4096;
	localparam int DEFAULT_MAX_HEIGHT = 4096;
	localparam int QUEUE_DEPTH        = 4;

	localparam logic [2:0] CFG_DEPTH_MODE   = 3'd0;
	localparam logic [2:0] CFG_IMAGE_WIDTH  = 3'd1;
	localparam logic [2:0] CFG_IMAGE_HEIGHT = 3'd2;
	localparam logic [2:0] CFG_BOTTOM_UP    = 3'd3;

	localparam logic [2:0] DEPTH_1  = 3'd0;
	localparam logic [2:0] DEPTH_4  = 3'd1;
	localparam logic [2:0] DEPTH_8  = 3'd2;
	localparam logic [2:0] DEPTH_24 = 3'd3;
	localparam logic [2:0] DEPTH_32 = 3'd4;

	localparam logic [2:0]  RESET_DEPTH_MODE   = DEPTH_8;
	localparam logic [12:0] RESET_IMAGE_WIDTH  = 13'd1;
	localparam logic [12:0] RESET_IMAGE_HEIGHT = 13'd1;
	localparam logic        RESET_BOTTOM_UP    = 1'b1;

	typedef enum logic [1:0] {
		KIND_BIT,
		KIND_NIBBLE,
		KIND_WORD
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] data;
		logic [3:0]  count;
		logic [11:0] col;
		logic [11:0] row;
		logic        done;
	} job_t;

endpackage

[rtl/bpru_front.sv]
// Front end: configuration registers, row position tracking and byte classification.
module bpru_front #(
	parameter int MAX_WIDTH  = bpru_pkg::DEFAULT_MAX_WIDTH,
	parameter int MAX_HEIGHT = bpru_pkg::DEFAULT_MAX_HEIGHT
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [2:0]      cfg_index,
	input  logic [12:0]     cfg_data,
	input  logic            take,
	input  logic [7:0]      data_byte,
	output logic            job_push,
	output bpru_pkg::job_t  job
);

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int BW = $clog2(4 * MAX_WIDTH + 4);

	logic [2:0]    depth_mode_q;
	logic [12:0]   image_width_q;
	logic [12:0]   image_height_q;
	logic          bottom_up_q;
	logic [BW-1:0] byte_in_row_q;
	logic [HW-1:0] source_row_q;
	logic [WW-1:0] pixel_col_q;
	logic [23:0]   partial_pixel_q;
	logic [1:0]    byte_in_pixel_q;

	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;
	logic [2:0]    mode;
	logic [BW-1:0] rb;
	logic [BW-1:0] rp;
	logic [BW-1:0] bir_inc;
	logic          in_data;
	logic          row_end;
	logic          wide_mode;
	logic          complete;
	logic [WW-1:0] rem;
	logic [3:0]    cnt;
	logic [WW-1:0] col_next;
	logic [HW-1:0] last_row;
	logic [HW-1:0] dest_row;
	logic          cfg_hit;

	always_comb begin
		if (image_width_q == 13'd0) begin
			w_eff = WW'(1);
		end else if (32'(image_width_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(image_width_q);
		end
		if (image_height_q == 13'd0) begin
			h_eff = HW'(1);
		end else if (32'(image_height_q) > MAX_HEIGHT) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(image_height_q);
		end
		mode = (depth_mode_q > bpru_pkg::DEPTH_32) ? bpru_pkg::DEPTH_8 : depth_mode_q;
	end

	always_comb begin
		unique case (mode)
			bpru_pkg::DEPTH_1:  rb = (BW'(w_eff) + BW'(7)) >> 3;
			bpru_pkg::DEPTH_4:  rb = (BW'(w_eff) + BW'(1)) >> 1;
			bpru_pkg::DEPTH_24: rb = (BW'(w_eff) << 1) + BW'(w_eff);
			bpru_pkg::DEPTH_32: rb = BW'(w_eff) << 2;
			default:            rb = BW'(w_eff);
		endcase
	end

	assign rp        = (rb + BW'(3)) & ~BW'(3);
	assign bir_inc   = byte_in_row_q + BW'(1);
	assign in_data   = byte_in_row_q < rb;
	assign row_end   = bir_inc >= rp;
	assign wide_mode = (mode == bpru_pkg::DEPTH_24) || (mode == bpru_pkg::DEPTH_32);
	assign complete  = (mode == bpru_pkg::DEPTH_24) ? (byte_in_pixel_q == 2'd2)
	                                                : (byte_in_pixel_q == 2'd3);
	assign rem       = w_eff - pixel_col_q;
	assign last_row  = h_eff - HW'(1);
	assign dest_row  = bottom_up_q ? (last_row - source_row_q) : source_row_q;
	assign col_next  = pixel_col_q + WW'(cnt);
	assign cfg_hit   = cfg_we && (cfg_index <= bpru_pkg::CFG_BOTTOM_UP);

	always_comb begin
		cnt       = 4'd0;
		job.kind  = bpru_pkg::KIND_WORD;
		job.data  = {24'd0, data_byte};
		unique case (mode)
			bpru_pkg::DEPTH_1: begin
				cnt      = (32'(rem) >= 32'd8) ? 4'd8 : 4'(rem);
				job.kind = bpru_pkg::KIND_BIT;
			end
			bpru_pkg::DEPTH_4: begin
				cnt      = (32'(rem) >= 32'd2) ? 4'd2 : 4'(rem);
				job.kind = bpru_pkg::KIND_NIBBLE;
			end
			bpru_pkg::DEPTH_24: begin
				cnt      = (complete && pixel_col_q < w_eff) ? 4'd1 : 4'd0;
				job.data = {8'd0, partial_pixel_q[7:0], partial_pixel_q[15:8], data_byte};
			end
			bpru_pkg::DEPTH_32: begin
				cnt      = (complete && pixel_col_q < w_eff) ? 4'd1 : 4'd0;
				job.data = {data_byte, partial_pixel_q[7:0], partial_pixel_q[15:8],
				            partial_pixel_q[23:16]};
			end
			default: begin
				cnt = (pixel_col_q < w_eff) ? 4'd1 : 4'd0;
			end
		endcase
		job.count = cnt;
		job.col   = 12'(pixel_col_q);
		job.row   = 12'(dest_row);
		job.done  = (source_row_q == last_row) && (col_next == w_eff);
	end

	assign job_push = take && in_data && (cnt != 4'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_mode_q    <= bpru_pkg::RESET_DEPTH_MODE;
			image_width_q   <= bpru_pkg::RESET_IMAGE_WIDTH;
			image_height_q  <= bpru_pkg::RESET_IMAGE_HEIGHT;
			bottom_up_q     <= bpru_pkg::RESET_BOTTOM_UP;
			byte_in_row_q   <= '0;
			source_row_q    <= '0;
			pixel_col_q     <= '0;
			partial_pixel_q <= '0;
			byte_in_pixel_q <= '0;
		end else if (cfg_hit) begin
			unique case (cfg_index)
				bpru_pkg::CFG_DEPTH_MODE:   depth_mode_q   <= cfg_data[2:0];
				bpru_pkg::CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				bpru_pkg::CFG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				default:                    bottom_up_q    <= cfg_data[0];
			endcase
			byte_in_row_q   <= '0;
			source_row_q    <= '0;
			pixel_col_q     <= '0;
			partial_pixel_q <= '0;
			byte_in_pixel_q <= '0;
		end else if (take) begin
			if (in_data) begin
				pixel_col_q <= col_next;
				if (wide_mode) begin
					if (complete) begin
						partial_pixel_q <= '0;
						byte_in_pixel_q <= '0;
					end else begin
						case (byte_in_pixel_q)
							2'd0:    partial_pixel_q[7:0]   <= data_byte;
							2'd1:    partial_pixel_q[15:8]  <= data_byte;
							default: partial_pixel_q[23:16] <= data_byte;
						endcase
						byte_in_pixel_q <= byte_in_pixel_q + 2'd1;
					end
				end
			end
			if (row_end) begin
				byte_in_row_q   <= '0;
				pixel_col_q     <= '0;
				partial_pixel_q <= '0;
				byte_in_pixel_q <= '0;
				source_row_q    <= (source_row_q == last_row) ? '0 : source_row_q + HW'(1);
			end else begin
				byte_in_row_q <= bir_inc;
			end
		end
	end

endmodule

[rtl/bpru_fifo.sv]
// Short job queue between the front end and the pixel expander.
module bpru_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  bpru_pkg::job_t wr_job,
	input  logic           rd_en,
	output bpru_pkg::job_t rd_job,
	output logic           full,
	output logic           empty
);

	localparam int DEPTH = bpru_pkg::QUEUE_DEPTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	bpru_pkg::job_t slots_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_wr;
	logic           do_rd;

	assign full   = count_q == CW'(DEPTH);
	assign empty  = count_q == '0;
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && !empty;
	assign rd_job = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slots_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (32'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (32'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

[rtl/bpru_back.sv]
// Back end: expands jobs into the result register, a pixel per cycle unless stalled.
module bpru_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_avail,
	input  bpru_pkg::job_t job,
	output logic           job_pop,
	input  logic           pop,
	output logic           empty,
	output logic [31:0]    pixel_word,
	output logic [11:0]    dest_row,
	output logic [11:0]    dest_col,
	output logic           last_of_run,
	output logic           image_done
);

	logic [2:0]  k_q;
	logic        out_valid_q;
	logic [2:0]  bit_sel;
	logic [31:0] word;
	logic        last;
	logic        advance;
	logic        emit;

	assign bit_sel = 3'd7 - k_q;
	assign last    = ({1'b0, k_q} + 4'd1) == job.count;
	assign advance = !out_valid_q || pop;
	assign emit    = advance && job_avail;
	assign job_pop = emit && last;
	assign empty   = !out_valid_q;

	always_comb begin
		unique case (job.kind)
			bpru_pkg::KIND_BIT:    word = {31'd0, job.data[bit_sel]};
			bpru_pkg::KIND_NIBBLE: word = {28'd0, (k_q == 3'd0) ? job.data[7:4] : job.data[3:0]};
			default:               word = job.data;
		endcase
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pixel_word  <= word;
			dest_row    <= job.row;
			dest_col    <= job.col + 12'(k_q);
			last_of_run <= last;
			image_done  <= job.done && last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= job_avail;
			end
			if (emit) begin
				k_q <= last ? 3'd0 : k_q + 3'd1;
			end
		end
	end

endmodule

[rtl/bmp_pixel_row_unpacker_unit.sv]
// Top level of the bitmap pixel row unpacker.
//
// Input queue side: present data_byte with push; a transfer happens on a clock
// edge with push high and full low. Bytes are raw pixel data in file order,
// row padding included.
// Result queue side: while empty is low the oldest pixel sits on pixel_word,
// dest_row, dest_col, last_of_run and image_done; pop high transfers it.
// Configuration: cfg_valid with cfg_index and cfg_data writes one register;
// cfg_ready is always high. Write only while idle; any defined register write
// restarts the image at its first byte.
// Path: a byte that yields pixels is queued as a registered job, then its first pixel in the result register.
// Throughput: while pop keeps up, the expander puts out one pixel per cycle, so bytes of 8, 24 and
// 32 bit data stream at one per cycle; 4 bit and 1 bit data are slower per byte, as each byte yields
// up to 2 or 8 pixels; padding bytes make no pixels.
// A four-entry job queue decouples byte intake from pixel output.
// Reset: registers return to 8 bit, 1 x 1, bottom-up; queues empty.
// When pop stays low the result is held, the job queue fills and full rises.
module bmp_pixel_row_unpacker_unit #(
	parameter int MAX_WIDTH  = bpru_pkg::DEFAULT_MAX_WIDTH,
	parameter int MAX_HEIGHT = bpru_pkg::DEFAULT_MAX_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] pixel_word,
	output logic [11:0] dest_row,
	output logic [11:0] dest_col,
	output logic        last_of_run,
	output logic        image_done
);

	logic           take;
	logic           job_push;
	bpru_pkg::job_t front_job;
	bpru_pkg::job_t head_job;
	logic           job_pop;
	logic           q_empty;

	assign cfg_ready = 1'b1;
	assign take      = push && !full;

	bpru_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.take     (take),
		.data_byte(data_byte),
		.job_push (job_push),
		.job      (front_job)
	);

	bpru_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.wr_en (job_push),
		.wr_job(front_job),
		.rd_en (job_pop),
		.rd_job(head_job),
		.full  (full),
		.empty (q_empty)
	);

	bpru_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_avail  (!q_empty),
		.job        (head_job),
		.job_pop    (job_pop),
		.pop        (pop),
		.empty      (empty),
		.pixel_word (pixel_word),
		.dest_row   (dest_row),
		.dest_col   (dest_col),
		.last_of_run(last_of_run),
		.image_done (image_done)
	);

endmodule

[rtl/bpru_checker.sv]
// Port-level assertions for the bitmap pixel row unpacker, bound to the top level.
module bpru_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [31:0] pixel_word,
	input logic [11:0] dest_row,
	input logic [11:0] dest_col,
	input logic        last_of_run,
	input logic        image_done
);

	a_done_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (!image_done || last_of_run))
		else $error("image_done without last_of_run");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(pixel_word) && $stable(dest_row)
		                      && $stable(dest_col) && $stable(last_of_run)))
		else $error("stalled result changed");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !last_of_run) |=> !empty)
		else $error("gap inside a run of pixels");

	a_run_columns: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !last_of_run) |=>
			(dest_col == $past(dest_col) + 12'd1) && (dest_row == $past(dest_row)))
		else $error("run pixels not on consecutive columns");

endmodule

bind bmp_pixel_row_unpacker_unit bpru_checker u_bpru_checker (.*);

[bench/tb_top.sv]
// Self-checking bench for the bitmap pixel row unpacker: byte stream in, predicted pixels checked.
module tb_top;

	localparam int         LIMIT_CYCLES    = 200000;
	localparam int         SETTLE_CYCLES   = 12;
	localparam int         HOLD_CYCLES     = 300;
	localparam int         RANDOM_BYTES    = 56;
	localparam int         STEADY_BYTES    = 30;
	localparam logic [2:0] CFG_UNUSED_LOW  = 3'd4;
	localparam logic [2:0] DEPTH_UNDEFINED = 3'd7;

	typedef struct packed {
		logic [31:0] word;
		logic [11:0] row;
		logic [11:0] col;
		logic        last;
		logic        done;
	} pixel_t;

	class pixel_tracker;
		logic [2:0]  depth;
		logic [12:0] width_reg;
		logic [12:0] height_reg;
		logic        flip;
		int unsigned byte_in_row;
		int unsigned source_row;
		int unsigned pixel_col;
		int unsigned byte_in_pixel;
		logic [31:0] partial;
		pixel_t      held;
		bit          have_held;
		pixel_t      pending_pixels[$];
		int unsigned failures;

		function new();
			depth = bpru_pkg::RESET_DEPTH_MODE;
			width_reg = bpru_pkg::RESET_IMAGE_WIDTH;
			height_reg = bpru_pkg::RESET_IMAGE_HEIGHT;
			flip = bpru_pkg::RESET_BOTTOM_UP;
			failures = 0;
			clear_position();
		endfunction

		function void clear_position();
			byte_in_row = 0;
			source_row = 0;
			pixel_col = 0;
			byte_in_pixel = 0;
			partial = '0;
		endfunction

		function void set_register(logic [2:0] index, logic [12:0] value);
			case (index)
				bpru_pkg::CFG_DEPTH_MODE:   depth = value[2:0];
				bpru_pkg::CFG_IMAGE_WIDTH:  width_reg = value;
				bpru_pkg::CFG_IMAGE_HEIGHT: height_reg = value;
				bpru_pkg::CFG_BOTTOM_UP:    flip = value[0];
				default:                    return;
			endcase
			clear_position();
		endfunction

		function void geometry(output logic [2:0] mode, output int unsigned w, h, rb, rp);
			w = (width_reg == 0) ? 1 :
				(width_reg > bpru_pkg::DEFAULT_MAX_WIDTH) ? bpru_pkg::DEFAULT_MAX_WIDTH :
				width_reg;
			h = (height_reg == 0) ? 1 :
				(height_reg > bpru_pkg::DEFAULT_MAX_HEIGHT) ? bpru_pkg::DEFAULT_MAX_HEIGHT :
				height_reg;
			mode = (depth > bpru_pkg::DEPTH_32) ? bpru_pkg::DEPTH_8 : depth;
			case (mode)
				bpru_pkg::DEPTH_1:  rb = (w + 7) / 8;
				bpru_pkg::DEPTH_4:  rb = (w + 1) / 2;
				bpru_pkg::DEPTH_24: rb = w * 3;
				bpru_pkg::DEPTH_32: rb = w * 4;
				default:            rb = w;
			endcase
			rp = (rb + 3) / 4 * 4;
		endfunction

		function void emit_pixel(logic [31:0] word, int unsigned w, int unsigned h);
			int unsigned row;
			row = flip ? h - 1 - source_row : source_row;
			if (have_held)
				pending_pixels.push_back(held);
			held.word = word;
			held.row = row[11:0];
			held.col = pixel_col[11:0];
			held.last = 1'b0;
			held.done = (source_row == h - 1) && (pixel_col == w - 1);
			have_held = 1'b1;
			pixel_col++;
		endfunction

		function void accept_byte(logic [7:0] b);
			logic [2:0]  mode;
			int unsigned w, h, rb, rp, need, idx;
			int          k;
			logic [7:0]  red, alpha;
			geometry(mode, w, h, rb, rp);
			have_held = 1'b0;
			if (source_row >= h)
				source_row = 0;
			if (byte_in_row < rb) begin
				case (mode) inside
					bpru_pkg::DEPTH_1: begin
						for (k = 0; k < 8; k++)
							if (pixel_col < w)
								emit_pixel({31'b0, b[7 - k]}, w, h);
					end
					bpru_pkg::DEPTH_4: begin
						if (pixel_col < w)
							emit_pixel({28'b0, b[7:4]}, w, h);
						if (pixel_col < w)
							emit_pixel({28'b0, b[3:0]}, w, h);
					end
					bpru_pkg::DEPTH_24, bpru_pkg::DEPTH_32: begin
						need = (mode == bpru_pkg::DEPTH_24) ? 3 : 4;
						idx = byte_in_pixel & 3;
						if (idx + 1 < need) begin
							partial |= {24'b0, b} << (8 * idx);
							byte_in_pixel = idx + 1;
						end else begin
							red = (mode == bpru_pkg::DEPTH_24) ? b : partial[23:16];
							alpha = (mode == bpru_pkg::DEPTH_32) ? b : 8'h00;
							if (pixel_col < w)
								emit_pixel({alpha, partial[7:0], partial[15:8], red}, w, h);
							partial = '0;
							byte_in_pixel = 0;
						end
					end
					default: begin
						if (pixel_col < w)
							emit_pixel({24'b0, b}, w, h);
					end
				endcase
			end
			byte_in_row++;
			if (byte_in_row >= rp) begin
				byte_in_row = 0;
				pixel_col = 0;
				partial = '0;
				byte_in_pixel = 0;
				source_row++;
				if (source_row >= h)
					source_row = 0;
			end
			if (have_held) begin
				held.last = 1'b1;
				pending_pixels.push_back(held);
			end
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
				failures++;
			end
		endfunction

		function void check_pixel(pixel_t got);
			pixel_t want;
			if (pending_pixels.size() == 0) begin
				$display("%0t: pixel with nothing expected, actual word %h row %0d col %0d",
					$time, got.word, got.row, got.col);
				failures++;
				return;
			end
			want = pending_pixels.pop_front();
			compare_field("pixel_word", want.word, got.word);
			compare_field("dest_row", 32'(want.row), 32'(got.row));
			compare_field("dest_col", 32'(want.col), 32'(got.col));
			compare_field("last_of_run", 32'(want.last), 32'(got.last));
			compare_field("image_done", 32'(want.done), 32'(got.done));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [12:0] cfg_data = '0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  data_byte = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [31:0] pixel_word;
	logic [11:0] dest_row;
	logic [11:0] dest_col;
	logic        last_of_run;
	logic        image_done;

	pixel_tracker tracker = new();
	bit           calm = 1'b0;
	bit           hold_req = 1'b0;
	int           hold_left = 0;
	int unsigned  random_left = 0;
	int           cycles;

	bmp_pixel_row_unpacker_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.push        (push),
		.full        (full),
		.data_byte   (data_byte),
		.empty       (empty),
		.pop         (pop),
		.pixel_word  (pixel_word),
		.dest_row    (dest_row),
		.dest_col    (dest_col),
		.last_of_run (last_of_run),
		.image_done  (image_done)
	);

	always #10 clk = ~clk;

	task automatic send_byte(logic [7:0] b);
		while (!calm && $urandom_range(99) < 37) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		data_byte <= b;
		@(posedge clk);
		while (full)
			@(posedge clk);
		tracker.accept_byte(b);
	endtask

	// drop push, wait out every pixel, then let the unit settle
	task automatic settle();
		push <= 1'b0;
		while (tracker.pending_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] index, logic [12:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		tracker.set_register(index, value);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(logic [2:0] mode, logic [12:0] w, logic [12:0] h, logic bu);
		settle();
		write_reg(bpru_pkg::CFG_DEPTH_MODE, {10'($urandom), mode});
		write_reg(bpru_pkg::CFG_IMAGE_WIDTH, w);
		write_reg(bpru_pkg::CFG_IMAGE_HEIGHT, h);
		write_reg(bpru_pkg::CFG_BOTTOM_UP, {12'($urandom), bu});
	endtask

	task automatic random_phase(bit steady);
		logic [2:0]  mode;
		logic [12:0] w, h;
		logic [2:0]  mode_used;
		int unsigned wu, hu, rb, rp, count;
		mode = ($urandom_range(9) < 8) ? 3'($urandom_range(4)) : 3'($urandom_range(7, 5));
		case ($urandom_range(9))
			0:       w = 13'd0;
			1:       w = 13'd4096;
			2:       w = 13'($urandom_range(8191, 4097));
			default: w = 13'($urandom_range(20, 1));
		endcase
		case ($urandom_range(9))
			0:       h = 13'd0;
			1:       h = 13'd4096;
			2:       h = 13'($urandom_range(8191, 4097));
			default: h = 13'($urandom_range(5, 1));
		endcase
		configure(mode, w, h, 1'($urandom_range(1)));
		if ($urandom_range(2) == 0)
			write_reg(3'(CFG_UNUSED_LOW + $urandom_range(3)), 13'($urandom));
		tracker.geometry(mode_used, wu, hu, rb, rp);
		if (steady)
			count = STEADY_BYTES;
		else if (rp <= 64 && $urandom_range(3) != 0)
			count = rp * $urandom_range(3, 1);
		else
			count = $urandom_range(24, 1);
		if (count > random_left)
			count = random_left;
		random_left -= count;
		calm = steady;
		repeat (count) send_byte(8'($urandom));
		calm = 1'b0;
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty)
				tracker.check_pixel({pixel_word, dest_row, dest_col, last_of_run, image_done});
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= calm || $urandom_range(99) >= 37;
			end
		end
	end

	initial begin
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		int phase;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: 1 x 1 image, wrap into the next image
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h5A);
		send_byte(8'hA5);
		send_byte(8'hFF);

		configure(bpru_pkg::DEPTH_1, 13'd10, 13'd2, 1'b0);
		send_byte(8'hA5);
		send_byte(8'hC0);
		send_byte(8'h3F);
		send_byte(8'h00);

		configure(bpru_pkg::DEPTH_4, 13'd3, 13'd0, 1'b1);
		send_byte(8'hF0);
		send_byte(8'h3C);
		send_byte(8'h77);
		send_byte(8'h11);

		configure(bpru_pkg::DEPTH_24, 13'd1, 13'd2, 1'b1);
		send_byte(8'h10);
		send_byte(8'h20);
		send_byte(8'h30);
		send_byte(8'hEE);

		configure(bpru_pkg::DEPTH_32, 13'd1, 13'd1, 1'b0);
		send_byte(8'h01);
		send_byte(8'h02);
		send_byte(8'h03);
		send_byte(8'hFF);

		// undefined depth code, zero width, saturated height; spare index must not restart
		configure(DEPTH_UNDEFINED, 13'd0, 13'd8191, 1'b1);
		send_byte(8'h80);
		send_byte(8'h00);
		settle();
		write_reg(CFG_UNUSED_LOW, 13'h1FFF);
		send_byte(8'hFF);
		send_byte(8'h55);
		send_byte(8'h42);

		random_left = RANDOM_BYTES;
		phase = 0;
		while (random_left > 0) begin
			random_phase(phase == 0);
			phase++;
		end

		// hold off the receiver so the job queue fills and full rises
		configure(bpru_pkg::DEPTH_8, 13'd16, 13'd4, 1'b0);
		hold_req = 1'b1;
		repeat (20) send_byte(8'($urandom));

		// saturated width, start of the widest row
		configure(bpru_pkg::DEPTH_1, 13'd8191, 13'd1, 1'b1);
		repeat (8) send_byte(8'($urandom));

		push <= 1'b0;
		while (tracker.pending_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.failures == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

[filelist.f]
rtl/bpru_pkg.sv
rtl/bpru_front.sv
rtl/bpru_fifo.sv
rtl/bpru_back.sv
rtl/bmp_pixel_row_unpacker_unit.sv
rtl/bpru_checker.sv
bench/tb_top.sv
